// ===== hdl/sclut_pkg.sv =====
`timescale 1ns / 1ps

package sclut_pkg;

    localparam int unsigned TABLE_SIZE   = 256;
    localparam int unsigned PHASE_W      = 16;
    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned FRAC_W       = 16;
    localparam int unsigned IDX_W        = $clog2(TABLE_SIZE);
    localparam int unsigned POS_W        = PHASE_W + IDX_W;
    localparam int unsigned SERIES_TERMS = 8;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    typedef logic [PHASE_W-1:0]         phase_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [IDX_W-1:0]           index_t;
    typedef logic [FRAC_W-1:0]          frac_t;
    typedef sample_t                    table_t [TABLE_SIZE];

    // Unsigned quotient by shift and subtract, one quotient bit per step.
    function automatic longint unsigned udiv64(longint unsigned num,
                                               longint unsigned den);
        longint unsigned quo;
        longint unsigned part;
        quo  = '0;
        part = '0;
        for (int i = 63; i >= 0; i--)
        begin
            part = {part[62:0], num[i]};
            if (part >= den)
            begin
                part   = part - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series in Q2.30, starting from x (sine) or from one (cosine).
    function automatic longint series_q30(longint unsigned x, longint unsigned x2,
                                          bit is_sine);
        longint unsigned term;
        longint          sum;
        int unsigned     n;
        term = is_sine ? x : ONE_Q30;
        n    = is_sine ? 1 : 0;
        sum  = 0;
        for (int unsigned i = 0; i < SERIES_TERMS; i++)
        begin
            if ((i & 1) == 0)
                sum = sum + longint'(term);
            else
                sum = sum - longint'(term);
            term = udiv64((term * x2) >> 30, 64'((n + 1) * (n + 2)));
            n    = n + 2;
        end
        return sum;
    endfunction

    function automatic sample_t round_q15(longint v);
        longint r;
        if (v < 0)
            v = 0;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767)
            r = 32767;
        return sample_t'(r);
    endfunction

    // One full turn of samples; the first quarter comes from the series and
    // the other quadrants are folded from it.
    function automatic table_t build_table(bit is_cosine);
        table_t          t;
        int unsigned     quarter;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned x2;
        sample_t         s;
        sample_t         c;
        for (int unsigned k = 0; k < TABLE_SIZE; k++)
        begin
            quarter = (4 * k) / TABLE_SIZE;
            rem     = longint'((4 * k) % TABLE_SIZE);
            x       = (rem * HALF_PI_Q30) / TABLE_SIZE;
            x2      = (x * x) >> 30;
            s       = round_q15(series_q30(x, x2, 1'b1));
            c       = round_q15(series_q30(x, x2, 1'b0));
            case (quarter & 3)
                0:       t[k] = is_cosine ? c  : s;
                1:       t[k] = is_cosine ? -s : c;
                2:       t[k] = is_cosine ? -c : -s;
                default: t[k] = is_cosine ? s  : -c;
            endcase
        end
        return t;
    endfunction

    localparam table_t SINE_TABLE   = build_table(1'b0);
    localparam table_t COSINE_TABLE = build_table(1'b1);

endpackage

// ===== hdl/sine_cosine_lut_interpolator.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                Word
// input     in_valid / in_ready      phase
// output    out_valid / out_ready    sine_out, cosine_out
//
// Four register stages: index split, table read, difference times fraction,
// then the sum into the output register. One word is taken every cycle while
// the output is not stalled. Each stage moves when the one after it is empty or
// moving, so a stall at the output fills the bubbles first and then holds the
// input. Reset clears only the valid bits; the tables are constant logic.
module sine_cosine_lut_interpolator
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sclut_pkg::phase_t phase,
    output logic              out_valid,
    input  logic              out_ready,
    output sclut_pkg::sample_t sine_out,
    output sclut_pkg::sample_t cosine_out
);
    import sclut_pkg::*;

    localparam int unsigned PROD_W = SAMPLE_W + FRAC_W + 2;

    // Stage 1: table index, next index and fraction.
    logic   s1_valid_reg;
    index_t s1_idx_reg;
    index_t s1_nxt_reg;
    frac_t  s1_frac_reg;
    index_t s1_idx_next;
    index_t s1_nxt_next;
    frac_t  s1_frac_next;
    logic [POS_W-1:0] pos;

    // Stage 2: the four samples.
    logic    s2_valid_reg;
    sample_t s2_sin_a_reg;
    sample_t s2_sin_b_reg;
    sample_t s2_cos_a_reg;
    sample_t s2_cos_b_reg;
    frac_t   s2_frac_reg;

    // Stage 3: products and base samples.
    logic                     s3_valid_reg;
    logic signed [PROD_W-1:0] s3_sin_prod_reg;
    logic signed [PROD_W-1:0] s3_cos_prod_reg;
    sample_t                  s3_sin_a_reg;
    sample_t                  s3_cos_a_reg;
    logic signed [PROD_W-1:0] s3_sin_prod_next;
    logic signed [PROD_W-1:0] s3_cos_prod_next;

    // Stage 4: output register.
    logic    out_valid_reg;
    sample_t sine_out_reg;
    sample_t cosine_out_reg;
    sample_t sine_out_next;
    sample_t cosine_out_next;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic s4_ready;

    assign s4_ready = !out_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign out_valid  = out_valid_reg;
    assign sine_out   = sine_out_reg;
    assign cosine_out = cosine_out_reg;

    always_comb
    begin
        pos          = POS_W'(phase) * POS_W'(TABLE_SIZE);
        s1_idx_next  = pos[POS_W-1:FRAC_W];
        s1_frac_next = pos[FRAC_W-1:0];
        // The last entry interpolates toward entry zero.
        if (s1_idx_next == index_t'(TABLE_SIZE - 1))
            s1_nxt_next = '0;
        else
            s1_nxt_next = s1_idx_next + index_t'(1);
    end

    always_comb
    begin
        s3_sin_prod_next = (PROD_W'(s2_sin_b_reg) - PROD_W'(s2_sin_a_reg))
                           * $signed({2'b00, s2_frac_reg});
        s3_cos_prod_next = (PROD_W'(s2_cos_b_reg) - PROD_W'(s2_cos_a_reg))
                           * $signed({2'b00, s2_frac_reg});
    end

    // The arithmetic shift floors, so a negative step rounds toward minus infinity.
    always_comb
    begin
        sine_out_next   = s3_sin_a_reg + SAMPLE_W'(s3_sin_prod_reg >>> FRAC_W);
        cosine_out_next = s3_cos_a_reg + SAMPLE_W'(s3_cos_prod_reg >>> FRAC_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_idx_reg  <= s1_idx_next;
            s1_nxt_reg  <= s1_nxt_next;
            s1_frac_reg <= s1_frac_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_sin_a_reg <= SINE_TABLE[s1_idx_reg];
            s2_sin_b_reg <= SINE_TABLE[s1_nxt_reg];
            s2_cos_a_reg <= COSINE_TABLE[s1_idx_reg];
            s2_cos_b_reg <= COSINE_TABLE[s1_nxt_reg];
            s2_frac_reg  <= s1_frac_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_sin_prod_reg <= s3_sin_prod_next;
            s3_cos_prod_reg <= s3_cos_prod_next;
            s3_sin_a_reg    <= s2_sin_a_reg;
            s3_cos_a_reg    <= s2_cos_a_reg;
        end
        if (s4_ready && s3_valid_reg)
        begin
            sine_out_reg   <= sine_out_next;
            cosine_out_reg <= cosine_out_next;
        end
    end

endmodule
